### hw/rtl/bgra_alpha_over_blend_assert.svh
// Assertion macros for the BGRA source-over blender.
// Used by the port checker; has no dependencies of its own.
`ifndef BGRA_ALPHA_OVER_BLEND_ASSERT_SVH
`define BGRA_ALPHA_OVER_BLEND_ASSERT_SVH
// Property checked at each rising edge outside reset.
`define ABOB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at each rising edge, reset included.
`define ABOB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### hw/rtl/abob_pkg.sv
// Types and constants shared by the BGRA source-over blender.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package abob_pkg;
	localparam int CH_COUNT = 3;  // blue, green, red
	localparam int CH_W     = 8;
	localparam int PROD_W   = 16;
	localparam int NUM_W    = 24;
	localparam int WGT_W    = 16;
	localparam int PIX_W    = 32;
	localparam int QUO_W    = 8;

	typedef logic [CH_W-1:0] chan_t;

	// Data carried along the chain of divider cells.
	typedef struct packed {
		logic [CH_COUNT-1:0][NUM_W-1:0] rem;
		logic [CH_COUNT-1:0][QUO_W-1:0] quo;
		logic [WGT_W-1:0]               weight;
		chan_t                          alpha;
		logic                           eof;
	} abob_work_t;
endpackage
`default_nettype wire

### hw/rtl/abob_if.sv
// Stream interfaces of the BGRA source-over blender.
// Depends on nothing but widths fixed by the pixel format.
`timescale 1ns / 1ps
`default_nettype none
interface abob_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_pixel;
	logic [31:0] target_pixel;
	logic        end_of_frame;
	modport source (output valid, source_pixel, target_pixel, end_of_frame, input ready);
	modport sink (input valid, source_pixel, target_pixel, end_of_frame, output ready);
endinterface

interface abob_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] blended_pixel;
	logic        frame_done;
	modport source (output valid, blended_pixel, frame_done, input ready);
	modport sink (input valid, blended_pixel, frame_done, output ready);
endinterface
`default_nettype wire

### hw/rtl/abob_front.sv
// Front end: forms the products, the blend weight, the numerators and the alpha.
// Depends on abob_pkg and abob_in_if.
`timescale 1ns / 1ps
`default_nettype none
module abob_front (
	input  wire                 clk,
	input  wire                 arst_n,
	abob_in_if.sink             pix_in,
	output logic                out_valid,
	input  wire                 out_ready,
	output abob_pkg::abob_work_t out_work
);
	import abob_pkg::*;

	logic                               v1_q, v2_q;
	logic                               r1, r2;
	chan_t                              sa_s1;
	logic [PROD_W-1:0]                  tw_s1;
	logic [CH_COUNT-1:0][PROD_W-1:0]    prod_s1;
	logic [CH_COUNT-1:0][CH_W-1:0]      tc_s1;
	logic                               eof_s1;
	abob_work_t                         work_s2;
	chan_t                              sa, ta;
	logic [WGT_W-1:0]                   weight;
	logic [WGT_W:0]                     alpha_sum;
	abob_work_t                         work_d;

	assign r2 = !v2_q || out_ready;
	assign r1 = !v1_q || r2;
	assign pix_in.ready = r1;
	assign sa = pix_in.source_pixel[31:24];
	assign ta = pix_in.target_pixel[31:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (r1) v1_q <= pix_in.valid;
			if (r2) v2_q <= v1_q;
		end
	end

	// Stage one: one 8 by 8 product per channel and the target share of the weight.
	always_ff @(posedge clk) begin
		if (r1 && pix_in.valid) begin
			sa_s1  <= sa;
			tw_s1  <= PROD_W'(ta) * PROD_W'(8'hFF - sa);
			eof_s1 <= pix_in.end_of_frame;
			for (int c = 0; c < CH_COUNT; c++) begin
				prod_s1[c] <= PROD_W'(sa) * PROD_W'(pix_in.source_pixel[c*CH_W +: CH_W]);
				tc_s1[c]   <= pix_in.target_pixel[c*CH_W +: CH_W];
			end
		end
	end

	// Stage two: numerators, weight and alpha, where alpha = floor(weight / 255).
	always_comb begin
		weight    = WGT_W'({sa_s1, 8'h00}) - WGT_W'(sa_s1) + tw_s1;
		alpha_sum = (WGT_W+1)'(weight) + (WGT_W+1)'(1) + (WGT_W+1)'(weight[15:8]);
		work_d        = '0;
		work_d.weight = weight;
		work_d.alpha  = alpha_sum[15:8];
		work_d.eof    = eof_s1;
		for (int c = 0; c < CH_COUNT; c++) begin
			work_d.rem[c] = NUM_W'({prod_s1[c], 8'h00}) - NUM_W'(prod_s1[c])
				+ NUM_W'(tw_s1) * NUM_W'(tc_s1[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (r2 && v1_q) work_s2 <= work_d;
	end

	assign out_valid = v2_q;
	assign out_work  = work_s2;
endmodule
`default_nettype wire

### hw/rtl/abob_div_cell.sv
// One cell of the divider chain: settles one quotient bit of each channel.
// Depends on abob_pkg.
`timescale 1ns / 1ps
`default_nettype none
module abob_div_cell #(
	parameter int BIT = 7
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  abob_pkg::abob_work_t in_work,
	output logic                out_valid,
	input  wire                 out_ready,
	output abob_pkg::abob_work_t out_work
);
	import abob_pkg::*;

	logic       valid_q;
	abob_work_t work_q;
	abob_work_t work_d;
	logic [NUM_W-1:0] divisor;

	assign in_ready = !valid_q || out_ready;
	assign divisor  = NUM_W'(in_work.weight) << BIT;

	always_comb begin
		work_d = in_work;
		for (int c = 0; c < CH_COUNT; c++) begin
			if (in_work.rem[c] >= divisor) begin
				work_d.rem[c]      = in_work.rem[c] - divisor;
				work_d.quo[c][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (in_ready) valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) work_q <= work_d;
	end

	assign out_valid = valid_q;
	assign out_work  = work_q;
endmodule
`default_nettype wire

### hw/rtl/bgra_alpha_over_blend.sv
// Source-over blend of two straight-alpha BGRA pixels. Each transfer on pix_in
// carries a source and a target pixel; one transfer on pix_out returns the blended
// pixel and a copy of the end-of-frame mark. On its way to pix_out a pixel passes
// through the front-end stages for the products and the weight, eight cells of
// the divider chain (one quotient bit per cell) and one output register, the
// first of these being loaded by the input transfer itself. The chain takes a
// new pixel in every cycle while pix_out is not stalled, so the sustained rate
// is one pixel per clock; each stage holds its data only while the stage after it
// is full and stalled, so bubbles close up under back-pressure.
// Alpha is floor(W / 255) and each colour floor(N / W), with W the blend weight;
// a pixel whose alphas are both zero comes out as zero.
`timescale 1ns / 1ps
`default_nettype none
module bgra_alpha_over_blend (
	input  wire        clk,
	input  wire        arst_n,
	abob_in_if.sink    pix_in,
	abob_out_if.source pix_out
);
	import abob_pkg::*;

	localparam int CELLS = QUO_W;

	logic       chain_valid [CELLS+1];
	logic       chain_ready [CELLS+1];
	abob_work_t chain_work  [CELLS+1];
	logic       out_valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic       eof_q;
	abob_work_t last;

	// Front end feeds the head of the chain.
	abob_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_work  (chain_work[0])
	);

	// Restoring division, most significant quotient bit first.
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		abob_div_cell #(.BIT(CELLS-1-i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_work   (chain_work[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_work  (chain_work[i+1])
		);
	end

	// Output register: assembles the pixel and forces zero when the weight is zero.
	assign last = chain_work[CELLS];
	assign chain_ready[CELLS] = !out_valid_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (chain_ready[CELLS]) out_valid_q <= chain_valid[CELLS];
	end

	always_ff @(posedge clk) begin
		if (chain_ready[CELLS] && chain_valid[CELLS]) begin
			eof_q <= last.eof;
			if (last.weight == '0) pixel_q <= '0;
			else pixel_q <= {last.alpha, last.quo[2], last.quo[1], last.quo[0]};
		end
	end

	assign pix_out.valid         = out_valid_q;
	assign pix_out.blended_pixel = pixel_q;
	assign pix_out.frame_done    = eof_q;
endmodule
`default_nettype wire

### hw/rtl/abob_checker.sv
// Port checker for the BGRA source-over blender, bound to the top level.
// Depends on bgra_alpha_over_blend_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "bgra_alpha_over_blend_assert.svh"
module abob_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] out_pixel,
	input wire        out_eof
);
	`ABOB_ASSERT(a_out_hold, clk, arst_n,
		out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_eof),
		"stalled result changed")
	`ABOB_ASSERT(a_in_free, clk, arst_n, !out_valid || out_ready |-> in_ready,
		"input refused while output side free")
	`ABOB_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid,
		"result shown during reset")
	`ABOB_ASSERT(a_no_early, clk, arst_n, $past(!arst_n) |-> !out_valid,
		"result shown right after reset")
endmodule

bind bgra_alpha_over_blend abob_checker u_abob_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_pixel (pix_out.blended_pixel),
	.out_eof   (pix_out.frame_done)
);
`default_nettype wire
